/* hdl/taint_color_mix_table_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the mix table
// Shared property templates used at the end of the RTL modules.
// ----------------------------------------------------------------------------
`ifndef TAINT_COLOR_MIX_TABLE_DEFINES_SVH
`define TAINT_COLOR_MIX_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCMT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tcmt_pkg.sv */
// ----------------------------------------------------------------------------
// tcmt_pkg
// Types and constants shared by the mix table cells and the top level.
// ----------------------------------------------------------------------------
package tcmt_pkg;

   localparam int COLOR_W = 16;
   localparam int DEPTH_DEFAULT = 256;
   localparam logic [COLOR_W-1:0] EMPTY_DEFAULT = '0;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_LOOKUP = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_HIT       = 3'd3,
      ST_MISS      = 3'd4
   } status_type;

   // request word as it walks the cell row
   typedef struct packed {
      logic               live;
      action_type         action;
      logic               done;
      status_type         status;
      logic [COLOR_W-1:0] color;
      logic [COLOR_W-1:0] lo;
      logic [COLOR_W-1:0] hi;
      logic [COLOR_W-1:0] found;
   } token_type;

endpackage

/* hdl/taint_color_mix_table.sv */
// ----------------------------------------------------------------------------
// taint_color_mix_table
// Mix table for taint colors, built as a row of slot cells walked by each word.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser
//  req_    | in  | mix_color, first_parent, second_parent | action
//  rsp_    | out | found_color                            | status
//
//  An accepted word walks the cell row one slot per cycle while the row is not
//  frozen; the row has TABLE_DEPTH cells, so a result passes every cell
//  register and then lands in the output register, and the next word is
//  taken once busy clears as the result leaves the row: one word is in
//  flight at a time. Reset empties every slot at once. A result held by a
//  stalled rsp_ side freezes the row when the next result reaches the end.
// ----------------------------------------------------------------------------
`include "taint_color_mix_table_defines.svh"

module taint_color_mix_table #(
   parameter int                             TABLE_DEPTH = tcmt_pkg::DEPTH_DEFAULT,
   parameter logic [tcmt_pkg::COLOR_W-1:0]   EMPTY_VALUE = tcmt_pkg::EMPTY_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [3*tcmt_pkg::COLOR_W-1:0]   req_tdata,  // mix_color, first_parent, second_parent
   input  logic                             req_tuser,  // action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tcmt_pkg::COLOR_W-1:0]     rsp_tdata,  // found_color
   output logic [2:0]                       rsp_tuser   // status
);
   import tcmt_pkg::*;

   token_type          tok [TABLE_DEPTH+1];
   logic               accept;
   logic               adv;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, end_status;
   logic [COLOR_W-1:0] rsp_data_ff;
   logic [COLOR_W-1:0] pa, pb;
   token_type          last;
   logic               rsp_plain;

   assign pa = req_tdata[2*COLOR_W-1:COLOR_W];
   assign pb = req_tdata[3*COLOR_W-1:2*COLOR_W];

   // one word in flight at a time
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;

   // build the entry word: order the parents, smaller first
   always_comb begin
      tok[0].live   = accept;
      tok[0].action = action_type'(req_tuser);
      tok[0].done   = 1'b0;
      tok[0].status = ST_MISS;
      tok[0].color  = req_tdata[COLOR_W-1:0];
      tok[0].lo     = (pa <= pb) ? pa : pb;
      tok[0].hi     = (pa <= pb) ? pb : pa;
      tok[0].found  = EMPTY_VALUE;
   end

   assign last = tok[TABLE_DEPTH];

   // freeze the row only when a finished word meets a stalled output
   assign adv = !(last.live && rsp_valid_ff && !rsp_tready);

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      tcmt_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .up_tok (tok[i]),
         .dn_tok (tok[i+1])
      );
   end

   // word that ran off the row unanswered: full on insert, miss on lookup
   always_comb begin
      if (last.done) begin
         end_status = last.status;
      end else if (last.action == ACT_INSERT) begin
         end_status = ST_FULL;
      end else begin
         end_status = ST_MISS;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (last.live && adv) begin
         rsp_valid_in = 1'b1;
         busy_in      = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result until the rsp_ side takes it
   always_ff @(posedge clock) begin
      if (last.live && adv) begin
         rsp_status_ff <= end_status;
         rsp_data_ff   <= last.found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign rsp_plain = rsp_valid_ff && (rsp_status_ff != ST_HIT);

   `TCMT_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy_ff, "accepted word not tracked")
   `TCMT_ASSERT_NOW(a_idle_row_empty, clock, reset, !busy_ff, !last.live, "word at row end")
   `TCMT_ASSERT_NOW(a_status_range, clock, reset, rsp_valid_ff, rsp_status_ff <= ST_MISS, "bad status")
   `TCMT_ASSERT_NOW(a_insert_empty, clock, reset, rsp_plain, rsp_data_ff == EMPTY_VALUE, "color on non-hit")

endmodule

/* hdl/tcmt_cell.sv */
// ----------------------------------------------------------------------------
// tcmt_cell
// One table slot: holds a mix entry and acts on the word passing through.
// ----------------------------------------------------------------------------
`include "taint_color_mix_table_defines.svh"

module tcmt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  tcmt_pkg::token_type up_tok,
   output tcmt_pkg::token_type dn_tok
);
   import tcmt_pkg::*;

   logic               valid_ff, valid_in;
   logic [COLOR_W-1:0] color_ff, lo_ff, hi_ff;
   logic               wr_en;
   logic               ins_live;
   token_type          tok_ff, tok_in;

   assign ins_live = up_tok.live && (up_tok.action == ACT_INSERT);

   always_comb begin
      tok_in   = up_tok;
      wr_en    = 1'b0;
      valid_in = valid_ff;
      if (up_tok.live && !up_tok.done) begin
         if (up_tok.action == ACT_INSERT) begin
            if (valid_ff && (color_ff == up_tok.color)) begin
               tok_in.done   = 1'b1;
               tok_in.status = ST_DUPLICATE;
            end else if (!valid_ff) begin
               // first free slot: no duplicate seen ahead, claim it
               tok_in.done   = 1'b1;
               tok_in.status = ST_INSERTED;
               wr_en         = adv;
               valid_in      = valid_ff | adv;
            end
         end else if (valid_ff && (lo_ff == up_tok.lo) && (hi_ff == up_tok.hi)) begin
            tok_in.done   = 1'b1;
            tok_in.status = ST_HIT;
            tok_in.found  = color_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         tok_ff.live <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (adv) begin
            tok_ff.live <= tok_in.live;
         end
      end
      if (adv) begin
         tok_ff.action <= tok_in.action;
         tok_ff.done   <= tok_in.done;
         tok_ff.status <= tok_in.status;
         tok_ff.color  <= tok_in.color;
         tok_ff.lo     <= tok_in.lo;
         tok_ff.hi     <= tok_in.hi;
         tok_ff.found  <= tok_in.found;
      end
      if (wr_en) begin
         color_ff <= up_tok.color;
         lo_ff    <= up_tok.lo;
         hi_ff    <= up_tok.hi;
      end
   end

   assign dn_tok = tok_ff;

   `TCMT_ASSERT_NEXT(a_slot_sticky, clock, reset, valid_ff, valid_ff, "slot lost its entry")
   `TCMT_ASSERT_NOW(a_write_free, clock, reset, wr_en, !valid_ff, "write into an occupied slot")
   `TCMT_ASSERT_NOW(a_write_live, clock, reset, wr_en, ins_live, "write without an insert word")

endmodule

/* bench/tcmt_mix_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mix table checker
// Watches both channels of the mix table and keeps its own copy of the
// slot store. It predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module tcmt_mix_checker #(
   parameter int                           TABLE_DEPTH = tcmt_pkg::DEPTH_DEFAULT,
   parameter logic [tcmt_pkg::COLOR_W-1:0] EMPTY_VALUE = tcmt_pkg::EMPTY_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [3*tcmt_pkg::COLOR_W-1:0] req_tdata,  // mix_color, first_parent, second_parent
   input  logic                           req_tuser,  // action
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [tcmt_pkg::COLOR_W-1:0]   rsp_tdata,  // found_color
   input  logic [2:0]                     rsp_tuser,  // status
   output int unsigned                    mismatch_count,
   output int unsigned                    results_due
);
   import tcmt_pkg::*;

   typedef struct packed {
      status_type         status;
      logic [COLOR_W-1:0] found;
   } mix_answer_type;

   mix_answer_type     answers_due [$];
   logic [COLOR_W-1:0] slot_color [TABLE_DEPTH];
   logic [COLOR_W-1:0] slot_lo [TABLE_DEPTH];
   logic [COLOR_W-1:0] slot_hi [TABLE_DEPTH];
   int                 slots_filled;

   // Slots fill from the bottom and are never freed, so slot i is in use
   // exactly when i < slots_filled.
   function automatic mix_answer_type mix_predict(action_type act,
                                                  logic [COLOR_W-1:0] color,
                                                  logic [COLOR_W-1:0] pa,
                                                  logic [COLOR_W-1:0] pb);
      mix_answer_type     answer;
      logic [COLOR_W-1:0] lo;
      logic [COLOR_W-1:0] hi;
      logic               matched;
      lo = (pa <= pb) ? pa : pb;
      hi = (pa <= pb) ? pb : pa;
      answer.found = EMPTY_VALUE;
      matched = 1'b0;
      if (act == ACT_INSERT) begin
         for (int i = 0; i < slots_filled; i++)
            if (slot_color[i] == color) matched = 1'b1;
         if (matched) begin
            answer.status = ST_DUPLICATE;
         end else if (slots_filled >= TABLE_DEPTH) begin
            answer.status = ST_FULL;
         end else begin
            slot_color[slots_filled] = color;
            slot_lo[slots_filled] = lo;
            slot_hi[slots_filled] = hi;
            slots_filled++;
            answer.status = ST_INSERTED;
         end
      end else begin
         answer.status = ST_MISS;
         // lowest matching slot wins
         for (int i = 0; i < slots_filled; i++) begin
            if (!matched && slot_lo[i] == lo && slot_hi[i] == hi) begin
               matched = 1'b1;
               answer.status = ST_HIT;
               answer.found = slot_color[i];
            end
         end
      end
      return answer;
   endfunction

   always @(posedge clock) begin
      mix_answer_type want;
      mix_answer_type due;
      if (reset) begin
         slots_filled = 0;
         answers_due.delete();
         mismatch_count = 0;
         results_due <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               $display("%0t: result word with none due, status %0d found %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatch_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata !== want.found) begin
                  $display("%0t: found_color expected %h actual %h",
                           $time, want.found, rsp_tdata);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            due = mix_predict(action_type'(req_tuser),
                              req_tdata[COLOR_W-1:0],
                              req_tdata[2*COLOR_W-1:COLOR_W],
                              req_tdata[3*COLOR_W-1:2*COLOR_W]);
            answers_due = {answers_due, due};
         end
         results_due <= answers_due.size();
      end
   end

endmodule

/* bench/taint_color_mix_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mix table testbench
// Drives insert and lookup words into the mix table in random bursts while
// the result side stalls on its own pattern; the checker predicts and compares.
// ----------------------------------------------------------------------------
module taint_color_mix_table_tb;
   import tcmt_pkg::*;

   localparam int                 TABLE_DEPTH  = DEPTH_DEFAULT;
   localparam logic [COLOR_W-1:0] EMPTY_VALUE  = EMPTY_DEFAULT;
   localparam int                 RANDOM_ITEMS = 1630;
   // longest hold of the result side; the quiet limit is several times the
   // worst gap of hold + sender gap + one walk of the cell row
   localparam int                 HOLD_CYCLES  = 1500;
   localparam int                 QUIET_LIMIT  = 10000;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [3*COLOR_W-1:0] req_tdata;  // mix_color, first_parent, second_parent
   logic                 req_tuser;  // action
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [COLOR_W-1:0]   rsp_tdata;  // found_color
   logic [2:0]           rsp_tuser;  // status
   int unsigned          mismatch_count;
   int unsigned          results_due;

   // what has been offered as inserts, used to build duplicates and hits
   logic [COLOR_W-1:0]   inserted_colors [$];
   logic [2*COLOR_W-1:0] inserted_pairs [$];

   taint_color_mix_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .EMPTY_VALUE (EMPTY_VALUE)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   tcmt_mix_checker #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .EMPTY_VALUE (EMPTY_VALUE)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hold reset high from the start, release once
   initial begin
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Offer one word and hold it until the table takes it. Valid stays high
   // on return so a following word goes out back to back.
   task automatic offer_word(input action_type act, input logic [COLOR_W-1:0] color,
                             input logic [COLOR_W-1:0] pa, input logic [COLOR_W-1:0] pb);
      req_tvalid <= 1'b1;
      req_tdata <= {pb, pa, color};
      req_tuser <= act;
      if (act == ACT_INSERT) begin
         inserted_colors = {inserted_colors, color};
         inserted_pairs = {inserted_pairs, {pb, pa}};
      end
      do @(posedge clock); while (!req_tready);
   endtask

   // Parents: tiny and near-top values collide often, which builds repeated
   // pairs and equal parents; the rest spread over the whole range.
   function automatic logic [COLOR_W-1:0] pick_parent();
      logic [COLOR_W-1:0] value;
      case ($urandom_range(0, 3))
         0:       value = COLOR_W'($urandom_range(0, 3));
         1:       value = ~COLOR_W'($urandom_range(0, 3));
         default: value = COLOR_W'($urandom);
      endcase
      return value;
   endfunction

   // Drop valid and wait until every predicted result has come back. The
   // first edge is always taken, so a word accepted at the current edge is
   // already counted in results_due.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // sender: directed words, then random bursts
   initial begin : word_source
      int                   pick;
      int                   burst_left;
      int                   gap;
      logic [COLOR_W-1:0]   color;
      logic [2*COLOR_W-1:0] pair;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= ACT_INSERT;
      @(posedge clock);
      while (reset) @(posedge clock);

      // lookup into the empty table misses; mix_color is ignored
      offer_word(ACT_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000);
      // empty color stored as a mix, parents given high first
      offer_word(ACT_INSERT, EMPTY_VALUE, 16'h0005, 16'h0003);
      offer_word(ACT_LOOKUP, 16'hA5A5, 16'h0003, 16'h0005);
      // extreme colors and parents, both orders on lookup
      offer_word(ACT_INSERT, 16'hFFFF, 16'hFFFF, 16'h0000);
      offer_word(ACT_LOOKUP, 16'h0000, 16'h0000, 16'hFFFF);
      offer_word(ACT_LOOKUP, 16'h5A5A, 16'hFFFF, 16'h0000);
      // duplicate colors are refused, including the empty color
      offer_word(ACT_INSERT, 16'hFFFF, 16'h1111, 16'h2222);
      offer_word(ACT_INSERT, EMPTY_VALUE, 16'h3333, 16'h4444);
      // equal parents
      offer_word(ACT_INSERT, 16'h1234, 16'h7777, 16'h7777);
      offer_word(ACT_LOOKUP, 16'h0000, 16'h7777, 16'h7777);
      // second entry with an existing pair: lookup must return the earlier
      offer_word(ACT_INSERT, 16'h4321, 16'h0003, 16'h0005);
      offer_word(ACT_LOOKUP, 16'hFFFF, 16'h0005, 16'h0003);
      // sign-bit boundary
      offer_word(ACT_INSERT, 16'h8000, 16'h8000, 16'h7FFF);
      offer_word(ACT_LOOKUP, 16'h7FFF, 16'h7FFF, 16'h8000);
      // near misses
      offer_word(ACT_LOOKUP, 16'h1234, 16'hFFFF, 16'hFFFF);
      offer_word(ACT_LOOKUP, 16'h1234, 16'h7777, 16'h7778);
      offer_word(ACT_INSERT, 16'h0001, 16'hFFFE, 16'h0001);
      offer_word(ACT_LOOKUP, 16'h8000, 16'h0001, 16'hFFFE);
      offer_word(ACT_LOOKUP, COLOR_W'($urandom), 16'h0000, 16'h0000);
      offer_word(ACT_INSERT, 16'h00FF, 16'h0000, 16'h0000);
      offer_word(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0000);

      // let the directed words drain before the random part
      drain_results();

      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst_left == 0) begin
            // idle between bursts; long gaps now and then
            req_tvalid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 300)
                                               : $urandom_range(1, 20);
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // fresh insert; the table saturates part way through the run
            color = COLOR_W'($urandom);
            if ($urandom_range(0, 4) == 0) begin
               pair = inserted_pairs[$urandom_range(0, inserted_pairs.size() - 1)];
               offer_word(ACT_INSERT, color, pair[COLOR_W-1:0], pair[2*COLOR_W-1:COLOR_W]);
            end else begin
               offer_word(ACT_INSERT, color, pick_parent(), pick_parent());
            end
         end else if (pick < 55) begin
            // reuse a color already offered
            color = inserted_colors[$urandom_range(0, inserted_colors.size() - 1)];
            offer_word(ACT_INSERT, color, pick_parent(), pick_parent());
         end else if (pick < 85) begin
            // lookup of an offered pair, either order
            pair = inserted_pairs[$urandom_range(0, inserted_pairs.size() - 1)];
            if ($urandom_range(0, 1) == 0)
               offer_word(ACT_LOOKUP, COLOR_W'($urandom),
                          pair[COLOR_W-1:0], pair[2*COLOR_W-1:COLOR_W]);
            else
               offer_word(ACT_LOOKUP, COLOR_W'($urandom),
                          pair[2*COLOR_W-1:COLOR_W], pair[COLOR_W-1:0]);
         end else begin
            offer_word(ACT_LOOKUP, COLOR_W'($urandom), pick_parent(), pick_parent());
         end
         burst_left--;
         // pause once mid run until the table has answered everything
         if (n == RANDOM_ITEMS / 2) drain_results();
      end

      drain_results();
      // watch for stray words after the last one due
      repeat (2 * TABLE_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0)
         $display("taint_color_mix_table_tb: clean");
      else
         $display("taint_color_mix_table_tb: errors");
      $finish;
   end

   // receiver: segments of its own stall pattern, plus two long holds that
   // back the cell row up into req_tready while the sender keeps offering
   initial begin : result_sink
      int   mode;
      int   span;
      int   delivered;
      logic held_early;
      logic held_late;
      delivered = 0;
      held_early = 1'b0;
      held_late = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if ((delivered >= 60 && !held_early) || (delivered >= 1000 && !held_late)) begin
            if (delivered >= 1000) held_late = 1'b1;
            else held_early = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 600);
         for (int k = 0; k < span; k++) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 7) != 0);
               default: rsp_tready <= ((k % 97) < 60);
            endcase
            @(posedge clock);
            if (rsp_tvalid && rsp_tready) delivered++;
         end
      end
   end

   // watchdog: end the run if no word moves on either channel for too long
   initial begin : quiet_watch
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("taint_color_mix_table_tb: errors");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/tcmt_pkg.sv
hdl/tcmt_cell.sv
hdl/taint_color_mix_table.sv
bench/tcmt_mix_checker.sv
bench/taint_color_mix_table_tb.sv
